@@ design/rtprs_pkg.sv @@
// rtprs_pkg: shared types and constants for the rtp receiver statistics block
// used by rtprs_ctrl, rtprs_dpath and rtp_receiver_statistics; no dependencies
package rtprs_pkg;

  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PROB_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned DIV_CNT_W  = $clog2(FRAC_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROBATION_LEN  = 2'd0,
    CFG_MAX_DROPOUT    = 2'd1,
    CFG_MAX_MISORDER   = 2'd2
  } cfg_index_e;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [PROB_W-1:0]     MIN_SEQ_RST      = 4'd2;
  localparam logic [CFG_DATA_W-1:0] MAX_DROPOUT_RST  = 15'd3000;
  localparam logic [CFG_DATA_W-1:0] MAX_MISORDER_RST = 15'd100;
  localparam logic [SEQ_W-1:0]      MAX_SEQ_RST      = 16'hFFFF;
  localparam logic [SEQ_W:0]        BAD_SEQ_NONE     = 17'd65537;
  localparam logic [SEQ_W:0]        SEQ_SPAN         = 17'd65536;
  localparam logic [CNT_W-1:0]      WRAP_STEP        = 32'h0001_0000;
  localparam logic [CNT_W-1:0]      JITTER_ROUND     = 32'd8;
  localparam int unsigned           JITTER_SHIFT     = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEQ,
    ST_JIT,
    ST_EXT,
    ST_EXP,
    ST_CNT,
    ST_LINT,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic seq_step;
    logic jit_step;
    logic rpt_ext;
    logic rpt_exp;
    logic rpt_cnt;
    logic rpt_lint;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic div_last;
  } status_t;

endpackage

@@ design/rtprs_ctrl.sv @@
// rtprs_ctrl: sequencer for packet and report transactions, owns the handshakes
// depends on rtprs_pkg
module rtprs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rtprs_pkg::status_t  stat_i,
  output rtprs_pkg::cmd_t     cmd_o
);

  rtprs_pkg::ctrl_state_e state_q, state_d;
  logic                   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtprs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rtprs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (stat_i.kind == rtprs_pkg::KIND_REPORT) ? rtprs_pkg::ST_EXT
                                                              : rtprs_pkg::ST_SEQ;
        end
      end
      rtprs_pkg::ST_SEQ: begin
        cmd_o.seq_step = 1'b1;
        state_d = rtprs_pkg::ST_JIT;
      end
      rtprs_pkg::ST_JIT: begin
        cmd_o.jit_step = 1'b1;
        state_d = rtprs_pkg::ST_OUT;
      end
      rtprs_pkg::ST_EXT: begin
        cmd_o.rpt_ext = 1'b1;
        state_d = rtprs_pkg::ST_EXP;
      end
      rtprs_pkg::ST_EXP: begin
        cmd_o.rpt_exp = 1'b1;
        state_d = rtprs_pkg::ST_CNT;
      end
      rtprs_pkg::ST_CNT: begin
        cmd_o.rpt_cnt = 1'b1;
        state_d = rtprs_pkg::ST_LINT;
      end
      rtprs_pkg::ST_LINT: begin
        cmd_o.rpt_lint = 1'b1;
        state_d = rtprs_pkg::ST_DIV;
      end
      rtprs_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = rtprs_pkg::ST_OUT;
        end
      end
      rtprs_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = rtprs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rtprs_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/rtprs_dpath.sv @@
// rtprs_dpath: sequence tracker, jitter estimator, report arithmetic and
// bit-serial lost fraction divider; depends on rtprs_pkg
module rtprs_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rtprs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rtprs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  kind_i,
  input  logic [rtprs_pkg::SEQ_W-1:0]           seq_number_i,
  input  logic [rtprs_pkg::CNT_W-1:0]           packet_timestamp_i,
  input  logic [rtprs_pkg::CNT_W-1:0]           arrival_time_i,
  input  logic                                  arrival_valid_i,
  input  rtprs_pkg::cmd_t                       cmd_i,
  output rtprs_pkg::status_t                    stat_o,
  output logic                                  source_valid_o,
  output logic                                  in_order_o,
  output logic [rtprs_pkg::CNT_W-1:0]           extended_max_o,
  output logic [rtprs_pkg::CNT_W-1:0]           expected_count_o,
  output logic signed [rtprs_pkg::CNT_W-1:0]    lost_count_o,
  output logic [rtprs_pkg::FRAC_W-1:0]          lost_fraction_o,
  output logic [rtprs_pkg::CNT_W-1:0]           jitter_estimate_o
);

  localparam int unsigned SW = rtprs_pkg::SEQ_W;
  localparam int unsigned CW = rtprs_pkg::CNT_W;
  localparam int unsigned PW = rtprs_pkg::PROB_W;
  localparam int unsigned DW = rtprs_pkg::CFG_DATA_W;
  localparam int unsigned FW = rtprs_pkg::FRAC_W;
  localparam int unsigned NW = rtprs_pkg::DIV_CNT_W;

  // configuration
  logic [PW-1:0] min_seq_q;
  logic [DW-1:0] max_dropout_q, max_misorder_q;

  // tracker state
  logic [PW-1:0] probation_q, probation_d;
  logic [SW-1:0] max_seq_q, max_seq_d, base_seq_q, base_seq_d;
  logic [SW:0]   bad_seq_q, bad_seq_d;
  logic [CW-1:0] wrap_q, wrap_d, recv_q, recv_d, recv_prior_q, recv_prior_d;
  logic [CW-1:0] exp_prior_q, exp_prior_d, last_transit_q, last_transit_d;
  logic [CW-1:0] jitter_q, jitter_d;
  logic          tvalid_q, tvalid_d;

  // per-transaction working registers
  logic          kind_q, known_q, ok_q, succ_q;
  logic [SW-1:0] seq_q;
  logic [CW-1:0] transit_q, mag_q, shr_q;
  logic [CW-1:0] ext_q, exp_q, lost_q, expi_q, reci_q, rem_q;
  logic [FW-1:0] quo_q;
  logic          frac_zero_q, frac_sat_q;
  logic [NW-1:0] div_cnt_q;

  // output register
  logic                 sv_out_q, io_out_q;
  logic [CW-1:0]        ext_out_q, exp_out_q, jit_out_q;
  logic signed [CW-1:0] lost_out_q;
  logic [FW-1:0]        frac_out_q;

  logic [SW-1:0] gap;
  logic [PW-1:0] prob_dec;
  logic          succ, ok, do_init, fwd_ok, jump_ok;
  logic [CW-1:0] diff_fw, diff_bw, lint, ext_now;
  logic [CW:0]   rem_dbl, rem_sub;

  assign gap      = seq_q - max_seq_q;
  assign succ     = (gap == SW'(1));
  assign prob_dec = probation_q - PW'(1);
  assign fwd_ok   = ({1'b0, gap} < {{(SW + 1 - DW){1'b0}}, max_dropout_q});
  assign jump_ok  = ({1'b0, gap} <=
                     (rtprs_pkg::SEQ_SPAN - {{(SW + 1 - DW){1'b0}}, max_misorder_q}));

  always_comb begin
    probation_d    = probation_q;
    max_seq_d      = max_seq_q;
    base_seq_d     = base_seq_q;
    bad_seq_d      = bad_seq_q;
    wrap_d         = wrap_q;
    recv_d         = recv_q;
    recv_prior_d   = recv_prior_q;
    exp_prior_d    = exp_prior_q;
    last_transit_d = last_transit_q;
    jitter_d       = jitter_q;
    tvalid_d       = tvalid_q;
    ok             = 1'b0;
    do_init        = 1'b0;

    if (cmd_i.seq_step) begin
      priority if (probation_q != '0) begin
        max_seq_d = seq_q;
        if (succ) begin
          probation_d = prob_dec;
          ok          = 1'b1;
          do_init     = (prob_dec == '0);
        end else begin
          probation_d = (min_seq_q == '0) ? '0 : min_seq_q - PW'(1);
        end
      end else if (fwd_ok) begin
        if (seq_q < max_seq_q) begin
          wrap_d = wrap_q + rtprs_pkg::WRAP_STEP;
        end
        max_seq_d = seq_q;
        recv_d    = recv_q + CW'(1);
        ok        = succ;
      end else if (jump_ok) begin
        // two consecutive packets after a large jump: resync on the new source
        if ({1'b0, seq_q} == bad_seq_q) begin
          do_init = 1'b1;
          ok      = succ;
        end else begin
          bad_seq_d = {1'b0, seq_q + SW'(1)};
        end
      end else begin
        ok = 1'b0;
      end

      if (do_init) begin
        base_seq_d     = seq_q;
        max_seq_d      = seq_q;
        bad_seq_d      = rtprs_pkg::BAD_SEQ_NONE;
        wrap_d         = '0;
        exp_prior_d    = '0;
        recv_d         = CW'(1);
        recv_prior_d   = '0;
        jitter_d       = '0;
        last_transit_d = '0;
        tvalid_d       = 1'b0;
      end
    end

    if (cmd_i.jit_step) begin
      if (!known_q) begin
        jitter_d = '0;
      end else begin
        if (tvalid_q) begin
          jitter_d = jitter_q + (mag_q - shr_q);
        end
        last_transit_d = transit_q;
        tvalid_d       = 1'b1;
      end
    end

    if (cmd_i.rpt_cnt) begin
      exp_prior_d  = exp_q;
      recv_prior_d = recv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_seq_q      <= rtprs_pkg::MIN_SEQ_RST;
      max_dropout_q  <= rtprs_pkg::MAX_DROPOUT_RST;
      max_misorder_q <= rtprs_pkg::MAX_MISORDER_RST;
      probation_q    <= rtprs_pkg::MIN_SEQ_RST;
      max_seq_q      <= rtprs_pkg::MAX_SEQ_RST;
      base_seq_q     <= '0;
      bad_seq_q      <= rtprs_pkg::BAD_SEQ_NONE;
      wrap_q         <= '0;
      recv_q         <= '0;
      recv_prior_q   <= '0;
      exp_prior_q    <= '0;
      last_transit_q <= '0;
      jitter_q       <= '0;
      tvalid_q       <= 1'b0;
      div_cnt_q      <= '0;
    end else begin
      max_seq_q      <= max_seq_d;
      base_seq_q     <= base_seq_d;
      bad_seq_q      <= bad_seq_d;
      wrap_q         <= wrap_d;
      recv_q         <= recv_d;
      recv_prior_q   <= recv_prior_d;
      exp_prior_q    <= exp_prior_d;
      last_transit_q <= last_transit_d;
      jitter_q       <= jitter_d;
      tvalid_q       <= tvalid_d;
      // writing the probation length also reloads probation
      if (cfg_we_i && (cfg_index_i == rtprs_pkg::CFG_PROBATION_LEN)) begin
        probation_q <= cfg_data_i[PW-1:0];
      end else begin
        probation_q <= probation_d;
      end
      if (cfg_we_i) begin
        if (cfg_index_i == rtprs_pkg::CFG_PROBATION_LEN) begin
          min_seq_q <= cfg_data_i[PW-1:0];
        end
        if (cfg_index_i == rtprs_pkg::CFG_MAX_DROPOUT) begin
          max_dropout_q <= cfg_data_i;
        end
        if (cfg_index_i == rtprs_pkg::CFG_MAX_MISORDER) begin
          max_misorder_q <= cfg_data_i;
        end
      end
      if (cmd_i.rpt_lint) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + NW'(1);
      end
    end
  end

  // both differences in parallel, sign of the forward one picks the magnitude
  assign diff_fw = transit_q - last_transit_q;
  assign diff_bw = last_transit_q - transit_q;
  assign lint    = expi_q - reci_q;
  assign rem_dbl = {rem_q, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, expi_q};
  assign ext_now = wrap_q + {{(CW - SW){1'b0}}, max_seq_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_i;
      seq_q     <= seq_number_i;
      transit_q <= arrival_time_i - packet_timestamp_i;
      known_q   <= arrival_valid_i;
    end
    if (cmd_i.seq_step) begin
      mag_q  <= diff_fw[CW-1] ? diff_bw : diff_fw;
      shr_q  <= (jitter_q + rtprs_pkg::JITTER_ROUND) >> rtprs_pkg::JITTER_SHIFT;
      ok_q   <= ok;
      succ_q <= succ;
    end
    if (cmd_i.rpt_ext) begin
      ext_q <= ext_now;
    end
    if (cmd_i.rpt_exp) begin
      exp_q <= ext_q - {{(CW - SW){1'b0}}, base_seq_q} + CW'(1);
    end
    if (cmd_i.rpt_cnt) begin
      lost_q <= exp_q - recv_q;
      expi_q <= exp_q - exp_prior_q;
      reci_q <= recv_q - recv_prior_q;
    end
    if (cmd_i.rpt_lint) begin
      frac_zero_q <= (expi_q == '0) || (lint == '0) || lint[CW-1];
      // quotient above 255 exactly when interval loss reaches the interval
      frac_sat_q  <= (lint >= expi_q);
      rem_q       <= lint;
      quo_q       <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_dbl >= {1'b0, expi_q}) begin
        rem_q <= rem_sub[CW-1:0];
        quo_q <= {quo_q[FW-2:0], 1'b1};
      end else begin
        rem_q <= rem_dbl[CW-1:0];
        quo_q <= {quo_q[FW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      ext_out_q <= ext_now;
      jit_out_q <= jitter_q;
      if (kind_q == rtprs_pkg::KIND_REPORT) begin
        sv_out_q   <= 1'b0;
        io_out_q   <= 1'b0;
        exp_out_q  <= exp_q;
        lost_out_q <= $signed(lost_q);
        if (frac_zero_q) begin
          frac_out_q <= '0;
        end else if (frac_sat_q) begin
          frac_out_q <= '1;
        end else begin
          frac_out_q <= quo_q;
        end
      end else begin
        sv_out_q   <= ok_q;
        io_out_q   <= succ_q;
        exp_out_q  <= '0;
        lost_out_q <= '0;
        frac_out_q <= '0;
      end
    end
  end

  assign stat_o.kind     = kind_i;
  assign stat_o.div_last = (div_cnt_q == '1);

  assign source_valid_o    = sv_out_q;
  assign in_order_o        = io_out_q;
  assign extended_max_o    = ext_out_q;
  assign expected_count_o  = exp_out_q;
  assign lost_count_o      = lost_out_q;
  assign lost_fraction_o   = frac_out_q;
  assign jitter_estimate_o = jit_out_q;

endmodule

@@ design/rtp_receiver_statistics.sv @@
// rtp_receiver_statistics: top level, joins the sequencer and the datapath
// depends on rtprs_pkg, rtprs_ctrl, rtprs_dpath
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i, in_ready_o | kind, seq_number, packet_timestamp,
//           |                        | arrival_time, arrival_valid
//   out     | out_valid_o,out_ready_i| source_valid, in_order, extended_max,
//           |                        | expected_count, lost_count, lost_fraction,
//           |                        | jitter_estimate
//   cfg     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// a packet transaction runs the tracker step, jitter step and output load
// before the next accept. a report runs its count steps, then the 8-step
// restoring divider for the lost fraction. one transaction is in flight
// at a time. rst_ni clears all tracker state to its reset values and the
// registers to their defaults at once. a result waits in the output register;
// a new transaction is still taken and runs until it needs that register.
module rtp_receiver_statistics (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rtprs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rtprs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic [rtprs_pkg::SEQ_W-1:0]           seq_number_i,
  input  logic [rtprs_pkg::CNT_W-1:0]           packet_timestamp_i,
  input  logic [rtprs_pkg::CNT_W-1:0]           arrival_time_i,
  input  logic                                  arrival_valid_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  source_valid_o,
  output logic                                  in_order_o,
  output logic [rtprs_pkg::CNT_W-1:0]           extended_max_o,
  output logic [rtprs_pkg::CNT_W-1:0]           expected_count_o,
  output logic signed [rtprs_pkg::CNT_W-1:0]    lost_count_o,
  output logic [rtprs_pkg::FRAC_W-1:0]          lost_fraction_o,
  output logic [rtprs_pkg::CNT_W-1:0]           jitter_estimate_o
);

  rtprs_pkg::cmd_t    cmd;
  rtprs_pkg::status_t stat;

  rtprs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rtprs_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .kind_i             (kind_i),
    .seq_number_i       (seq_number_i),
    .packet_timestamp_i (packet_timestamp_i),
    .arrival_time_i     (arrival_time_i),
    .arrival_valid_i    (arrival_valid_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .source_valid_o     (source_valid_o),
    .in_order_o         (in_order_o),
    .extended_max_o     (extended_max_o),
    .expected_count_o   (expected_count_o),
    .lost_count_o       (lost_count_o),
    .lost_fraction_o    (lost_fraction_o),
    .jitter_estimate_o  (jitter_estimate_o)
  );

  // at most one datapath step per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.seq_step, cmd.jit_step, cmd.rpt_ext, cmd.rpt_exp,
              cmd.rpt_cnt, cmd.rpt_lint, cmd.div_step, cmd.out_load}))
    else $error("more than one datapath step active");

  // one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a transaction is in flight");

  // a loaded result is always offered next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("result loaded but not offered");

  // packet flags and report counts never share a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (lost_fraction_o != '0) |-> !source_valid_o && !in_order_o)
    else $error("report result carries packet flags");

endmodule

@@ dv/rtp_receiver_statistics_test.sv @@
// rtp_receiver_statistics_test: self-checking testbench for rtp_receiver_statistics
// predicts tracker, jitter and report fields for every transaction and checks each result
// depends on rtprs_pkg and rtp_receiver_statistics
module rtp_receiver_statistics_test;
  import rtprs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX   = 2'd3;
  localparam int unsigned          OUTPUT_HOLD_CYCLES = 500;

  typedef struct packed {
    logic             source_valid;
    logic             in_order;
    logic [CNT_W-1:0] extended_max;
    logic [CNT_W-1:0] expected_count;
    logic [CNT_W-1:0] lost_count;
    logic [FRAC_W-1:0] lost_fraction;
    logic [CNT_W-1:0] jitter_estimate;
  } stats_result_t;

  logic                    clk_i              = 1'b0;
  logic                    rst_ni             = 1'b0;
  logic                    cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i        = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i         = '0;
  logic                    in_valid_i         = 1'b0;
  logic                    in_ready_o;
  logic                    kind_i             = KIND_PACKET;
  logic [SEQ_W-1:0]        seq_number_i       = '0;
  logic [CNT_W-1:0]        packet_timestamp_i = '0;
  logic [CNT_W-1:0]        arrival_time_i     = '0;
  logic                    arrival_valid_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i        = 1'b0;
  logic                    source_valid_o;
  logic                    in_order_o;
  logic [CNT_W-1:0]        extended_max_o;
  logic [CNT_W-1:0]        expected_count_o;
  logic signed [CNT_W-1:0] lost_count_o;
  logic [FRAC_W-1:0]       lost_fraction_o;
  logic [CNT_W-1:0]        jitter_estimate_o;

  rtp_receiver_statistics uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .seq_number_i       (seq_number_i),
    .packet_timestamp_i (packet_timestamp_i),
    .arrival_time_i     (arrival_time_i),
    .arrival_valid_i    (arrival_valid_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .source_valid_o     (source_valid_o),
    .in_order_o         (in_order_o),
    .extended_max_o     (extended_max_o),
    .expected_count_o   (expected_count_o),
    .lost_count_o       (lost_count_o),
    .lost_fraction_o    (lost_fraction_o),
    .jitter_estimate_o  (jitter_estimate_o)
  );

  always #1 clk_i = ~clk_i;

  // predicted register values
  logic [PROB_W-1:0]     cfg_min_seq  = MIN_SEQ_RST;
  logic [CFG_DATA_W-1:0] cfg_dropout  = MAX_DROPOUT_RST;
  logic [CFG_DATA_W-1:0] cfg_misorder = MAX_MISORDER_RST;

  // predicted tracker state
  logic [SEQ_W-1:0]  trk_max        = MAX_SEQ_RST;
  logic [SEQ_W-1:0]  trk_base       = '0;
  logic [SEQ_W:0]    trk_bad        = BAD_SEQ_NONE;
  logic [CNT_W-1:0]  trk_wraps      = '0;
  logic [PROB_W-1:0] trk_probation  = MIN_SEQ_RST;
  logic [CNT_W-1:0]  rx_total       = '0;
  logic [CNT_W-1:0]  rx_at_report   = '0;
  logic [CNT_W-1:0]  exp_at_report  = '0;
  logic [CNT_W-1:0]  prev_transit   = '0;
  logic [CNT_W-1:0]  jitter_x16     = '0;
  logic              transit_stored = 1'b0;

  stats_result_t pending_stats[$];

  int mismatches     = 0;
  int packet_count   = 0;
  int report_count   = 0;
  int settings_count = 0;
  int burst_left     = 0;

  // receiver side
  logic        receiver_hold = 1'b0;
  logic [12:0] ready_pattern = 13'h0b5d;
  logic [1:0]  ready_mode    = 2'd0;
  logic [31:0] rx_cycle      = '0;

  // packet stream that the random traffic follows
  logic [SEQ_W-1:0] stream_seq     = 16'hFFFF;
  logic [CNT_W-1:0] stream_stamp   = 32'h1234_0000;
  logic [CNT_W-1:0] stream_transit = 32'h0000_4000;

  function automatic void restart_tracking(input logic [SEQ_W-1:0] seq);
    trk_base       = seq;
    trk_max        = seq;
    trk_bad        = BAD_SEQ_NONE;
    trk_wraps      = '0;
    exp_at_report  = '0;
    rx_total       = '0;
    rx_at_report   = '0;
    jitter_x16     = '0;
    prev_transit   = '0;
    transit_stored = 1'b0;
  endfunction

  function automatic stats_result_t predict_stats(input logic kind,
                                                  input logic [SEQ_W-1:0] seq,
                                                  input logic [CNT_W-1:0] stamp,
                                                  input logic [CNT_W-1:0] arrival,
                                                  input logic known);
    stats_result_t    r;
    logic [SEQ_W-1:0] gap;
    logic             next_one;
    logic             accepted;
    logic [CNT_W-1:0] transit;
    logic [CNT_W-1:0] diff;
    logic [CNT_W-1:0] mag;
    logic [CNT_W-1:0] round_term;
    logic [CNT_W-1:0] ext;
    logic [CNT_W-1:0] expected;
    logic [CNT_W-1:0] exp_int;
    logic [CNT_W-1:0] rec_int;
    logic [CNT_W-1:0] lost_int;
    logic [39:0]      scaled;
    r = '0;
    if (kind == KIND_PACKET) begin
      gap      = seq - trk_max;
      next_one = (gap == 16'd1);
      accepted = 1'b0;
      if (trk_probation != 4'd0) begin
        trk_max = seq;
        if (next_one) begin
          trk_probation = trk_probation - 4'd1;
          if (trk_probation == 4'd0) begin
            restart_tracking(seq);
            rx_total = rx_total + 32'd1;
          end
          accepted = 1'b1;
        end else begin
          trk_probation = (cfg_min_seq == 4'd0) ? 4'd0 : cfg_min_seq - 4'd1;
        end
      end else if (gap < cfg_dropout) begin
        if (seq < trk_max) trk_wraps = trk_wraps + WRAP_STEP;
        trk_max  = seq;
        rx_total = rx_total + 32'd1;
        accepted = next_one;
      end else if ({1'b0, gap} <= (SEQ_SPAN - {2'b00, cfg_misorder})) begin
        // second of two consecutive bad packets restarts the source
        if ({1'b0, seq} == trk_bad) begin
          restart_tracking(seq);
          rx_total = rx_total + 32'd1;
          accepted = next_one;
        end else begin
          trk_bad = {1'b0, seq + 16'd1};
        end
      end
      if (!known) begin
        jitter_x16 = '0;
      end else begin
        transit = arrival - stamp;
        if (transit_stored) begin
          diff       = transit - prev_transit;
          mag        = diff[31] ? (32'd0 - diff) : diff;
          round_term = (jitter_x16 + JITTER_ROUND) >> JITTER_SHIFT;
          jitter_x16 = jitter_x16 + mag - round_term;
        end
        prev_transit   = transit;
        transit_stored = 1'b1;
      end
      r.source_valid = accepted;
      r.in_order     = next_one;
      r.extended_max = trk_wraps + {16'd0, trk_max};
    end else begin
      ext           = trk_wraps + {16'd0, trk_max};
      expected      = ext - {16'd0, trk_base} + 32'd1;
      exp_int       = expected - exp_at_report;
      rec_int       = rx_total - rx_at_report;
      lost_int      = exp_int - rec_int;
      exp_at_report = expected;
      rx_at_report  = rx_total;
      // interval loss is signed, fraction saturates
      if (exp_int != 32'd0 && lost_int != 32'd0 && !lost_int[31]) begin
        scaled          = {lost_int, 8'd0} / {8'd0, exp_int};
        r.lost_fraction = (scaled > 40'd255) ? 8'hFF : scaled[7:0];
      end
      r.extended_max   = ext;
      r.expected_count = expected;
      r.lost_count     = expected - rx_total;
    end
    r.jitter_estimate = jitter_x16;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    stats_result_t got;
    stats_result_t want;
    logic [31:0]   fresh;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.source_valid    = source_valid_o;
      got.in_order        = in_order_o;
      got.extended_max    = extended_max_o;
      got.expected_count  = expected_count_o;
      got.lost_count      = lost_count_o;
      got.lost_fraction   = lost_fraction_o;
      got.jitter_estimate = jitter_estimate_o;
      if (pending_stats.size() == 0) begin
        $error("result transaction with no transaction pending");
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        check_field("source_valid", {31'd0, want.source_valid}, {31'd0, got.source_valid});
        check_field("in_order", {31'd0, want.in_order}, {31'd0, got.in_order});
        check_field("extended_max", want.extended_max, got.extended_max);
        check_field("expected_count", want.expected_count, got.expected_count);
        check_field("lost_count", want.lost_count, got.lost_count);
        check_field("lost_fraction", {24'd0, want.lost_fraction}, {24'd0, got.lost_fraction});
        check_field("jitter_estimate", want.jitter_estimate, got.jitter_estimate);
      end
    end
    fresh = $urandom;
    rx_cycle <= rx_cycle + 32'd1;
    // new stall pattern when the low byte of rx_cycle wraps, mode 0 stalls only under receiver_hold
    if (rx_cycle[7:0] == 8'd0) begin
      ready_pattern <= fresh[12:0] | 13'd1;
      ready_mode    <= fresh[14:13];
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[12:1]};
    end
    out_ready_i <= !receiver_hold && (ready_mode == 2'd0 || ready_pattern[0]);
  end

  task automatic send_rtp_item(input logic kind, input logic [SEQ_W-1:0] seq,
                               input logic [CNT_W-1:0] stamp,
                               input logic [CNT_W-1:0] arrival, input logic known);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i         <= 1'b1;
    kind_i             <= kind;
    seq_number_i       <= seq;
    packet_timestamp_i <= stamp;
    arrival_time_i     <= arrival;
    arrival_valid_i    <= known;
    do @(posedge clk_i); while (!in_ready_o);
    pending_stats.push_back(predict_stats(kind, seq, stamp, arrival, known));
    if (kind == KIND_PACKET) packet_count++;
    else report_count++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (index)
      CFG_PROBATION_LEN: begin
        cfg_min_seq   = data[PROB_W-1:0];
        trk_probation = data[PROB_W-1:0];
      end
      CFG_MAX_DROPOUT:  cfg_dropout = data;
      CFG_MAX_MISORDER: cfg_misorder = data;
      default: ;
    endcase
    settings_count++;
  endtask

  task automatic apply_settings(input logic [PROB_W-1:0] min_seq,
                                input logic [CFG_DATA_W-1:0] dropout,
                                input logic [CFG_DATA_W-1:0] misorder,
                                input logic stray);
    logic [31:0] noise;
    drain_results();
    noise = $urandom;
    if (stray) write_register(CFG_UNUSED_INDEX, noise[14:0]);
    // upper data bits beyond the register width are don't-care
    write_register(CFG_PROBATION_LEN, {noise[26:16], min_seq});
    write_register(CFG_MAX_DROPOUT, dropout);
    write_register(CFG_MAX_MISORDER, misorder);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_stream_traffic(input int count);
    int               sent;
    int               pick;
    int               run;
    logic [31:0]      r1;
    logic [31:0]      r2;
    logic [31:0]      r3;
    logic [31:0]      step;
    logic [SEQ_W-1:0] s;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      r1   = $urandom;
      r2   = $urandom;
      r3   = $urandom;
      step = $urandom_range(0, 300);
      stream_stamp = stream_stamp + 32'd160;
      if (pick < 9) begin
        send_rtp_item(KIND_REPORT, r1[15:0], r2, r3, r1[16]);
      end else if (pick < 13) begin
        send_rtp_item(KIND_PACKET, r1[15:0], r2, r3, r1[16]);
      end else if (pick < 19) begin
        // two consecutive packets somewhere else, forces a resync
        stream_seq     = r1[15:0];
        stream_stamp   = r2;
        stream_transit = r3;
        send_rtp_item(KIND_PACKET, stream_seq, stream_stamp, stream_stamp + stream_transit,
                      1'b1);
        stream_seq   = stream_seq + 16'd1;
        stream_stamp = stream_stamp + 32'd160;
        send_rtp_item(KIND_PACKET, stream_seq, stream_stamp,
                      stream_stamp + stream_transit + step, 1'b1);
        sent++;
      end else if (pick < 24) begin
        s = stream_seq - {13'd0, r1[2:0]};
        send_rtp_item(KIND_PACKET, s, stream_stamp, stream_stamp + stream_transit + step, 1'b1);
      end else if (pick < 28) begin
        stream_seq = stream_seq + {10'd0, r1[5:0]} + 16'd2;
        send_rtp_item(KIND_PACKET, stream_seq, stream_stamp,
                      stream_stamp + stream_transit + step, 1'b1);
      end else if (pick < 31) begin
        stream_seq = stream_seq + 16'd1;
        send_rtp_item(KIND_PACKET, stream_seq, stream_stamp, r2, 1'b0);
      end else begin
        // run of in-order packets, up to 20 long
        run = $urandom_range(1, 20);
        repeat (run) begin
          stream_seq   = stream_seq + 16'd1;
          stream_stamp = stream_stamp + 32'd160;
          step         = $urandom_range(0, 300);
          send_rtp_item(KIND_PACKET, stream_seq, stream_stamp,
                        stream_stamp + stream_transit + step, 1'b1);
        end
        sent += run - 1;
      end
      sent++;
    end
  endtask

  task automatic test_sequence_directed();
    // report straight after reset: whole span lost, fraction saturates
    send_rtp_item(KIND_REPORT, 16'd0, 32'd0, 32'd0, 1'b0);
    send_rtp_item(KIND_PACKET, 16'd0, 32'd0, 32'd0, 1'b1);
    // leaves probation and stores the first transit
    send_rtp_item(KIND_PACKET, 16'd1, 32'd0, 32'h8000_0000, 1'b1);
    // transit difference of minus two to the 31
    send_rtp_item(KIND_PACKET, 16'd2, 32'd0, 32'd0, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_rtp_item(KIND_PACKET, 16'd4, 32'hFFFF_FFFF, 32'h0000_0010, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd4, 32'hFFFF_FFFF, 32'h0000_0020, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd2, 32'd160, 32'h0000_0200, 1'b1);
    send_rtp_item(KIND_REPORT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // jump beyond the dropout window, then its successor
    send_rtp_item(KIND_PACKET, 16'd5000, 32'd320, 32'h0000_1000, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd5001, 32'd480, 32'h0000_1100, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd65534, 32'd640, 32'h0000_1200, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd65535, 32'd800, 32'h0000_1400, 1'b1);
    // sequence wrap
    send_rtp_item(KIND_PACKET, 16'd0, 32'd960, 32'h0000_1500, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd1, 32'd1120, 32'h0000_1640, 1'b1);
    // single bad packet, then back in order
    send_rtp_item(KIND_PACKET, 16'd40000, 32'd1280, 32'h0000_1700, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd2, 32'd1440, 32'h0000_1800, 1'b1);
    send_rtp_item(KIND_PACKET, 16'd10, 32'd1600, 32'h0000_1990, 1'b1);
    send_rtp_item(KIND_REPORT, 16'd0, 32'd0, 32'd0, 1'b0);
    send_rtp_item(KIND_PACKET, 16'd11, 32'd1760, 32'h0000_1A00, 1'b1);
    send_rtp_item(KIND_REPORT, 16'd0, 32'd0, 32'd0, 1'b0);
  endtask

  task automatic test_window_extremes();
    apply_settings(4'd1, 15'h7FFF, 15'h7FFF, 1'b0);
    send_stream_traffic(100);
    apply_settings(4'd15, 15'd1, 15'd1, 1'b0);
    send_stream_traffic(110);
    apply_settings(4'd0, 15'd0, 15'd0, 1'b0);
    send_stream_traffic(80);
  endtask

  task automatic test_unknown_register();
    apply_settings(MIN_SEQ_RST, MAX_DROPOUT_RST, MAX_MISORDER_RST, 1'b1);
    send_stream_traffic(90);
  endtask

  task automatic test_output_backpressure();
    apply_settings(4'd3, 15'd500, 15'd50, 1'b0);
    fork
      begin
        receiver_hold <= 1'b1;
        repeat (OUTPUT_HOLD_CYCLES) @(posedge clk_i);
        receiver_hold <= 1'b0;
      end
      send_stream_traffic(60);
    join
  endtask

  task automatic test_random_settings();
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    repeat (3) begin
      r1 = $urandom;
      r2 = $urandom_range(1, 4000);
      r3 = $urandom_range(1, 300);
      apply_settings(r1[3:0], r2[14:0], r3[14:0], r1[4]);
      send_stream_traffic(90);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_sequence_directed();
    test_window_extremes();
    test_unknown_register();
    test_output_backpressure();
    test_random_settings();
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("checked %0d packet and %0d report transactions over %0d register writes",
             packet_count, report_count, settings_count);
    $display("including a %0d-cycle output stall with the input side kept busy",
             OUTPUT_HOLD_CYCLES);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("rtp_receiver_statistics regression: pass");
    end else begin
      $display("rtp_receiver_statistics regression: fail");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("rtp_receiver_statistics regression: fail");
    $finish;
  end

endmodule
